// File: rtl/lltd_pkg.sv
`default_nettype none

package lltd_pkg;

   typedef logic [1:0] op_type;
   localparam op_type OP_DISPATCH = 2'd0;
   localparam op_type OP_ADD      = 2'd1;
   localparam op_type OP_REMOVE   = 2'd2;
   localparam op_type OP_BALANCE  = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type ST_DONE     = 2'd0;
   localparam status_type ST_EMPTY    = 2'd1;
   localparam status_type ST_BALANCED = 2'd2;
   localparam status_type ST_FULL     = 2'd3;

   localparam int IDX_BITS = 3;
   typedef logic [IDX_BITS-1:0] idx_type;

   localparam int Q_DEPTH      = 2;
   localparam int Q_PTR_BITS   = $clog2(Q_DEPTH);
   localparam int Q_LEVEL_BITS = $clog2(Q_DEPTH + 1);
   typedef logic [Q_LEVEL_BITS-1:0] q_level_type;

   // most group nesting levels that shared_levels can count
   localparam int MAX_LEVELS = 6;

   typedef struct packed {
      op_type  op;
      idx_type named;
      logic    named_ok;
   } task_req_type;

   // number of aligned groups that hold both processor i and processor j
   function automatic int shared_levels(input int i, input int j, input int levels);
      int n;
      n = 0;
      for (int b = 0; b < MAX_LEVELS; b++) begin
         if (b < levels && (i >> b) == (j >> b)) begin
            n = n + 1;
         end
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// File: rtl/least_loaded_task_dispatcher.sv
`default_nettype none

// channel   direction  handshake             payload
// req_      in         req_valid/req_stall   req_operation, req_processor_index
// rsp_      out        rsp_valid/rsp_stall   rsp_target_processor,
//                                            rsp_source_processor, rsp_status
//
// Requests are served one at a time behind a two-entry queue.
// Add or remove answers from S_NAMED (at once if that processor is absent).
// Dispatch or balance: S_SCAN, S_RDMIN, S_RDMAX, S_DECIDE, then S_WR2 when
// balance moves a task; the load scan visits one processor per cycle.
// Synchronous reset clears all counts and loads; no clearing pass is needed.
// A stalled response holds in its register; the queue takes requests until full.

module least_loaded_task_dispatcher #(
   parameter int PROCESSORS = 8,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_operation,
   input  wire logic [2:0]            req_processor_index,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [2:0]                 rsp_target_processor,
   output logic [2:0]                 rsp_source_processor,
   output logic [1:0]                 rsp_status
);

   logic                   q_valid;
   logic                   q_pop;
   lltd_pkg::task_req_type q_entry;
   lltd_pkg::q_level_type  q_level;
   logic                   busy;

   lltd_front #(
      .PROCESSORS (PROCESSORS)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_processor_index (req_processor_index),
      .q_valid             (q_valid),
      .q_entry             (q_entry),
      .q_pop               (q_pop),
      .q_level             (q_level)
   );

   lltd_back #(
      .PROCESSORS (PROCESSORS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_entry              (q_entry),
      .q_pop                (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_target_processor (rsp_target_processor),
      .rsp_source_processor (rsp_source_processor),
      .rsp_status           (rsp_status),
      .busy                 (busy)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      int'(q_level) <= lltd_pkg::Q_DEPTH)
      else $error("request queue over its depth");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> q_level != '0)
      else $error("accepted request missing from queue");

   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(q_valid) || $past(busy))
      else $error("response appeared with no request in flight");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid && !busy)
      else $error("queue popped while empty or engine busy");

endmodule

`default_nettype wire

// File: rtl/lltd_ram.sv
`default_nettype none

module lltd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/lltd_front.sv
`default_nettype none

module lltd_front #(
   parameter int PROCESSORS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire lltd_pkg::op_type       req_operation,
   input  wire lltd_pkg::idx_type      req_processor_index,
   output logic                        q_valid,
   output lltd_pkg::task_req_type      q_entry,
   input  wire logic                   q_pop,
   output lltd_pkg::q_level_type       q_level
);

   localparam int PTR_BITS = lltd_pkg::Q_PTR_BITS;

   lltd_pkg::task_req_type slot_ff [lltd_pkg::Q_DEPTH];
   lltd_pkg::task_req_type slot_in [lltd_pkg::Q_DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   lltd_pkg::q_level_type  level_ff, level_in;
   lltd_pkg::task_req_type classified;
   logic                   push;

   assign req_stall = (int'(level_ff) == lltd_pkg::Q_DEPTH);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (level_ff != '0);
   assign q_entry   = slot_ff[rd_ptr_ff];
   assign q_level   = level_ff;

   always_comb begin
      classified.op       = req_operation;
      classified.named    = req_processor_index;
      classified.named_ok = (int'(req_processor_index) < PROCESSORS);
   end

   always_comb begin
      slot_in   = slot_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         slot_in[wr_ptr_ff] = classified;
         wr_ptr_in          = PTR_BITS'(wr_ptr_ff + 1'b1);
      end
      if (q_pop) begin
         rd_ptr_in = PTR_BITS'(rd_ptr_ff + 1'b1);
      end
      if (push && !q_pop) begin
         level_in = lltd_pkg::q_level_type'(level_ff + 1'b1);
      end else if (!push && q_pop) begin
         level_in = lltd_pkg::q_level_type'(level_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/lltd_back.sv
`default_nettype none

module lltd_back #(
   parameter int PROCESSORS = 8,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_valid,
   input  wire lltd_pkg::task_req_type q_entry,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output lltd_pkg::idx_type           rsp_target_processor,
   output lltd_pkg::idx_type           rsp_source_processor,
   output lltd_pkg::status_type        rsp_status,
   output logic                        busy
);

   localparam int PIDX_BITS = $clog2(PROCESSORS);
   localparam int LEVELS    = PIDX_BITS;
   localparam int LOAD_BITS = COUNT_BITS + LEVELS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [PIDX_BITS-1:0]  LAST_IDX  = PIDX_BITS'(PROCESSORS - 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_NAMED  = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_RDMIN  = 3'd3;
   localparam logic [2:0] S_RDMAX  = 3'd4;
   localparam logic [2:0] S_DECIDE = 3'd5;
   localparam logic [2:0] S_WR2    = 3'd6;

   logic [2:0]                state_ff, state_in;
   lltd_pkg::op_type          op_ff, op_in;
   logic [PIDX_BITS-1:0]      named_ff, named_in;
   logic [PIDX_BITS-1:0]      idx_ff, idx_in;
   logic [PIDX_BITS-1:0]      min_i_ff, min_i_in;
   logic [PIDX_BITS-1:0]      max_i_ff, max_i_in;
   logic [LOAD_BITS-1:0]      min_load_ff, min_load_in;
   logic [LOAD_BITS-1:0]      max_load_ff, max_load_in;
   logic [COUNT_BITS-1:0]     cnt_min_ff, cnt_min_in;
   logic [LOAD_BITS-1:0]      load_ff [PROCESSORS];
   logic [LOAD_BITS-1:0]      load_in [PROCESSORS];
   logic [LOAD_BITS-1:0]      scan_ff [PROCESSORS];
   logic [LOAD_BITS-1:0]      scan_in [PROCESSORS];
   logic [PROCESSORS-1:0]     vld_ff, vld_in;
   logic                      rd_vld_ff;
   logic                      out_vld_ff, out_vld_in;
   lltd_pkg::idx_type         out_tgt_ff, out_tgt_in;
   lltd_pkg::idx_type         out_src_ff, out_src_in;
   lltd_pkg::status_type      out_st_ff, out_st_in;

   logic [PIDX_BITS-1:0]      rd_addr;
   logic [COUNT_BITS-1:0]     rd_data;
   logic [COUNT_BITS-1:0]     cnt_rd;
   logic                      wr_en;
   logic                      wr_up;
   logic [PIDX_BITS-1:0]      wr_addr;
   logic [COUNT_BITS-1:0]     wr_data;
   logic                      emit;
   lltd_pkg::idx_type         e_tgt;
   lltd_pkg::idx_type         e_src;
   lltd_pkg::status_type      e_st;
   logic                      out_free;

   lltd_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (PROCESSORS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // a count never written since reset reads as zero
   assign cnt_rd   = rd_vld_ff ? rd_data : '0;
   assign out_free = !out_vld_ff || !rsp_stall;

   assign rsp_valid            = out_vld_ff;
   assign rsp_target_processor = out_tgt_ff;
   assign rsp_source_processor = out_src_ff;
   assign rsp_status           = out_st_ff;
   assign busy                 = (state_ff != S_IDLE);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      named_in    = named_ff;
      idx_in      = idx_ff;
      min_i_in    = min_i_ff;
      max_i_in    = max_i_ff;
      min_load_in = min_load_ff;
      max_load_in = max_load_ff;
      cnt_min_in  = cnt_min_ff;
      scan_in     = scan_ff;
      q_pop       = 1'b0;
      rd_addr     = named_ff;
      wr_en       = 1'b0;
      wr_up       = 1'b1;
      wr_addr     = named_ff;
      wr_data     = '0;
      emit        = 1'b0;
      e_tgt       = lltd_pkg::idx_type'(named_ff);
      e_src       = '0;
      e_st        = lltd_pkg::ST_DONE;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop    = 1'b1;
               op_in    = q_entry.op;
               named_in = PIDX_BITS'(q_entry.named);
               unique case (q_entry.op) inside
                  lltd_pkg::OP_ADD, lltd_pkg::OP_REMOVE: begin
                     if (!q_entry.named_ok) begin
                        // no such processor: answer at once
                        emit  = 1'b1;
                        e_tgt = q_entry.named;
                        if (q_entry.op == lltd_pkg::OP_REMOVE) begin
                           e_src = q_entry.named;
                           e_st  = lltd_pkg::ST_EMPTY;
                        end else begin
                           e_st  = lltd_pkg::ST_FULL;
                        end
                     end else begin
                        rd_addr  = PIDX_BITS'(q_entry.named);
                        state_in = S_NAMED;
                     end
                  end
                  default: begin
                     idx_in      = '0;
                     min_i_in    = '0;
                     max_i_in    = '0;
                     min_load_in = '1;
                     max_load_in = '0;
                     scan_in     = load_ff;
                     state_in    = S_SCAN;
                  end
               endcase
            end
         end

         S_NAMED: begin
            emit     = 1'b1;
            state_in = S_IDLE;
            if (op_ff == lltd_pkg::OP_ADD) begin
               if (cnt_rd == COUNT_MAX) begin
                  e_st = lltd_pkg::ST_FULL;
               end else begin
                  wr_en   = 1'b1;
                  wr_data = cnt_rd + 1'b1;
               end
            end else begin
               e_src = lltd_pkg::idx_type'(named_ff);
               if (cnt_rd == '0) begin
                  e_st = lltd_pkg::ST_EMPTY;
               end else begin
                  wr_en   = 1'b1;
                  wr_up   = 1'b0;
                  wr_data = cnt_rd - 1'b1;
               end
            end
         end

         S_SCAN: begin
            // strict compares keep the lowest index on ties
            if (scan_ff[0] < min_load_ff) begin
               min_load_in = scan_ff[0];
               min_i_in    = idx_ff;
            end
            if (scan_ff[0] > max_load_ff) begin
               max_load_in = scan_ff[0];
               max_i_in    = idx_ff;
            end
            for (int k = 0; k < PROCESSORS - 1; k++) begin
               scan_in[k] = scan_ff[k+1];
            end
            if (idx_ff == LAST_IDX) begin
               state_in = S_RDMIN;
            end else begin
               idx_in = PIDX_BITS'(idx_ff + 1'b1);
            end
         end

         S_RDMIN: begin
            rd_addr  = min_i_ff;
            state_in = S_RDMAX;
         end

         S_RDMAX: begin
            rd_addr    = max_i_ff;
            cnt_min_in = cnt_rd;
            state_in   = S_DECIDE;
         end

         S_DECIDE: begin
            emit     = 1'b1;
            e_tgt    = lltd_pkg::idx_type'(min_i_ff);
            state_in = S_IDLE;
            if (op_ff == lltd_pkg::OP_DISPATCH) begin
               if (cnt_min_ff == COUNT_MAX) begin
                  e_st = lltd_pkg::ST_FULL;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = min_i_ff;
                  wr_data = cnt_min_ff + 1'b1;
               end
            end else begin
               e_src = lltd_pkg::idx_type'(max_i_ff);
               if ((max_load_ff - min_load_ff) < LOAD_BITS'(2)) begin
                  e_st = lltd_pkg::ST_BALANCED;
               end else if (cnt_rd == '0) begin
                  e_st = lltd_pkg::ST_EMPTY;
               end else if (cnt_min_ff == COUNT_MAX) begin
                  e_st = lltd_pkg::ST_FULL;
               end else begin
                  // take from the source now, give to the target next cycle
                  wr_en    = 1'b1;
                  wr_up    = 1'b0;
                  wr_addr  = max_i_ff;
                  wr_data  = cnt_rd - 1'b1;
                  state_in = S_WR2;
               end
            end
         end

         S_WR2: begin
            wr_en    = 1'b1;
            wr_addr  = min_i_ff;
            wr_data  = cnt_min_ff + 1'b1;
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // every processor sharing a group with the written one moves by one per shared level
   always_comb begin
      load_in = load_ff;
      vld_in  = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
         for (int i = 0; i < PROCESSORS; i++) begin
            if (wr_up) begin
               load_in[i] = load_ff[i]
                  + LOAD_BITS'(lltd_pkg::shared_levels(i, int'(wr_addr), LEVELS));
            end else begin
               load_in[i] = load_ff[i]
                  - LOAD_BITS'(lltd_pkg::shared_levels(i, int'(wr_addr), LEVELS));
            end
         end
      end
   end

   always_comb begin
      out_tgt_in = out_tgt_ff;
      out_src_in = out_src_ff;
      out_st_in  = out_st_ff;
      if (emit) begin
         out_vld_in = 1'b1;
         out_tgt_in = e_tgt;
         out_src_in = e_src;
         out_st_in  = e_st;
      end else if (rsp_stall) begin
         out_vld_in = out_vld_ff;
      end else begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      named_ff    <= named_in;
      idx_ff      <= idx_in;
      min_i_ff    <= min_i_in;
      max_i_ff    <= max_i_in;
      min_load_ff <= min_load_in;
      max_load_ff <= max_load_in;
      cnt_min_ff  <= cnt_min_in;
      scan_ff     <= scan_in;
      out_tgt_ff  <= out_tgt_in;
      out_src_ff  <= out_src_in;
      out_st_ff   <= out_st_in;
      if (reset) begin
         state_ff   <= S_IDLE;
         out_vld_ff <= 1'b0;
         vld_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         for (int i = 0; i < PROCESSORS; i++) begin
            load_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
         vld_ff     <= vld_in;
         rd_vld_ff  <= vld_ff[rd_addr];
         load_ff    <= load_in;
      end
   end

endmodule

`default_nettype wire

// File: test/dispatch_checker.sv
module dispatch_checker #(
   parameter int NPROC      = 8,
   parameter int COUNT_BITS = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_stall,
   input  wire logic [1:0] req_operation,
   input  wire logic [2:0] req_processor_index,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_stall,
   input  wire logic [2:0] rsp_target_processor,
   input  wire logic [2:0] rsp_source_processor,
   input  wire logic [1:0] rsp_status,
   output int              failures,
   output int              pending
);

   localparam int LEVELS = $clog2(NPROC);
   localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

   typedef struct packed {
      lltd_pkg::idx_type    target;
      lltd_pkg::idx_type    source;
      lltd_pkg::status_type status;
   } outcome_type;

   logic [COUNT_BITS-1:0] task_count [NPROC];
   outcome_type awaited_outcomes [$];
   int responses;

   task automatic report_mismatch(input string what, input int got, input int want);
      failures++;
      $display("mismatch at response %0d: %s is %0d, expected %0d",
               responses, what, got, want);
   endtask

   // mirror one request on the count table and return the response it earns
   function automatic outcome_type serve_request(input lltd_pkg::op_type op,
                                                 input lltd_pkg::idx_type named);
      outcome_type r;
      int unsigned load [NPROC];
      int unsigned lo_load;
      int unsigned hi_load;
      int lo_i;
      int hi_i;
      int base;
      r.target = named;
      r.source = '0;
      r.status = lltd_pkg::ST_DONE;
      case (op)
         lltd_pkg::OP_ADD: begin
            if (int'(named) >= NPROC) r.status = lltd_pkg::ST_FULL;
            else if (task_count[named] == COUNT_FULL) r.status = lltd_pkg::ST_FULL;
            else task_count[named] = task_count[named] + 1'b1;
         end
         lltd_pkg::OP_REMOVE: begin
            r.source = named;
            if (int'(named) >= NPROC) r.status = lltd_pkg::ST_EMPTY;
            else if (task_count[named] == '0) r.status = lltd_pkg::ST_EMPTY;
            else task_count[named] = task_count[named] - 1'b1;
         end
         default: begin
            // load of i: counts of every aligned group of size 1, 2, 4, ... holding i
            for (int i = 0; i < NPROC; i++) begin
               load[i] = 0;
               for (int b = 0; b < LEVELS; b++) begin
                  base = (i >> b) << b;
                  for (int k = 0; k < (1 << b); k++) begin
                     if (base + k < NPROC) load[i] += task_count[base + k];
                  end
               end
            end
            lo_load = 32'hFFFF_FFFF;
            hi_load = 0;
            lo_i = 0;
            hi_i = 0;
            for (int i = 0; i < NPROC; i++) begin
               if (load[i] < lo_load) begin
                  lo_load = load[i];
                  lo_i = i;
               end
               if (load[i] > hi_load) begin
                  hi_load = load[i];
                  hi_i = i;
               end
            end
            r.target = lltd_pkg::idx_type'(lo_i);
            if (op == lltd_pkg::OP_DISPATCH) begin
               if (task_count[lo_i] == COUNT_FULL) r.status = lltd_pkg::ST_FULL;
               else task_count[lo_i] = task_count[lo_i] + 1'b1;
            end else begin
               r.source = lltd_pkg::idx_type'(hi_i);
               if (hi_load - lo_load < 2) begin
                  r.status = lltd_pkg::ST_BALANCED;
               end else if (task_count[hi_i] == '0) begin
                  r.status = lltd_pkg::ST_EMPTY;
               end else if (task_count[lo_i] == COUNT_FULL) begin
                  r.status = lltd_pkg::ST_FULL;
               end else begin
                  task_count[hi_i] = task_count[hi_i] - 1'b1;
                  task_count[lo_i] = task_count[lo_i] + 1'b1;
               end
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch
      outcome_type want;
      if (reset) begin
         for (int i = 0; i < NPROC; i++) task_count[i] = '0;
         awaited_outcomes.delete();
         failures = 0;
         responses = 0;
      end else begin
         // responses first: a request taken at this edge cannot answer at this edge
         if (rsp_valid && !rsp_stall) begin
            if (awaited_outcomes.size() == 0) begin
               report_mismatch("response with no request outstanding, status",
                               rsp_status, 0);
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_target_processor !== want.target)
                  report_mismatch("target_processor", rsp_target_processor, want.target);
               if (rsp_source_processor !== want.source)
                  report_mismatch("source_processor", rsp_source_processor, want.source);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
            end
            responses++;
         end
         if (req_valid && !req_stall) begin
            awaited_outcomes.push_back(serve_request(
               lltd_pkg::op_type'(req_operation),
               lltd_pkg::idx_type'(req_processor_index)));
         end
      end
      pending = awaited_outcomes.size();
   end

endmodule

// File: test/least_loaded_task_dispatcher_tb.sv
module least_loaded_task_dispatcher_tb;

   localparam int NPROC       = 8;
   localparam int COUNT_BITS  = 16;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE      = 20;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   lltd_pkg::op_type     req_operation = lltd_pkg::OP_DISPATCH;
   lltd_pkg::idx_type    req_processor_index = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   lltd_pkg::idx_type    rsp_target_processor;
   lltd_pkg::idx_type    rsp_source_processor;
   lltd_pkg::status_type rsp_status;

   int failures;
   int pending;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   lltd_pkg::idx_type hot_proc = '0;
   logic hold_wanted = 1'b0;
   logic hold_begun = 1'b0;
   int hold_left = 0;
   int sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   least_loaded_task_dispatcher #(
      .PROCESSORS (NPROC),
      .COUNT_BITS (COUNT_BITS)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_processor_index  (req_processor_index),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_target_processor (rsp_target_processor),
      .rsp_source_processor (rsp_source_processor),
      .rsp_status           (rsp_status)
   );

   dispatch_checker #(
      .NPROC      (NPROC),
      .COUNT_BITS (COUNT_BITS)
   ) u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_processor_index  (req_processor_index),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_target_processor (rsp_target_processor),
      .rsp_source_processor (rsp_source_processor),
      .rsp_status           (rsp_status),
      .failures             (failures),
      .pending              (pending)
   );

   // receiver: random stalls, or one long hold once it is asked for
   always @(negedge clock) begin
      if (hold_wanted && !hold_begun) begin
         hold_begun <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic send_request(input lltd_pkg::op_type op, input lltd_pkg::idx_type idx);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_processor_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic send_random();
      int pick;
      lltd_pkg::op_type op;
      lltd_pkg::idx_type idx;
      pick = $urandom_range(99);
      if (pick < 30) op = lltd_pkg::OP_DISPATCH;
      else if (pick < 55) op = lltd_pkg::OP_ADD;
      else if (pick < 78) op = lltd_pkg::OP_REMOVE;
      else op = lltd_pkg::OP_BALANCE;
      // lean on one processor now and then so the loads drift apart
      idx = ($urandom_range(3) == 0) ? hot_proc
                                     : lltd_pkg::idx_type'($urandom_range(NPROC - 1));
      send_request(op, idx);
   endtask

   task automatic wait_quiet(input int settle);
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic run_phase(input int snd, input int rcv, input lltd_pkg::idx_type hot,
                            input int count);
      send_idle_pct = snd;
      recv_idle_pct = rcv;
      hot_proc = hot;
      repeat (count) send_random();
      wait_quiet(SETTLE);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table: nothing to balance, nothing to remove
      send_request(lltd_pkg::OP_BALANCE, 3'd0);
      send_request(lltd_pkg::OP_REMOVE, 3'd0);
      send_request(lltd_pkg::OP_REMOVE, 3'd7);
      send_request(lltd_pkg::OP_DISPATCH, 3'd5);
      send_request(lltd_pkg::OP_DISPATCH, 3'd2);
      send_request(lltd_pkg::OP_DISPATCH, 3'd7);
      // pile onto the top processor, then let balance spread it
      repeat (4) send_request(lltd_pkg::OP_ADD, 3'd7);
      send_request(lltd_pkg::OP_ADD, 3'd0);
      send_request(lltd_pkg::OP_ADD, 3'd3);
      repeat (3) send_request(lltd_pkg::OP_BALANCE, 3'd6);
      send_request(lltd_pkg::OP_REMOVE, 3'd7);
      send_request(lltd_pkg::OP_REMOVE, 3'd3);
      send_request(lltd_pkg::OP_REMOVE, 3'd0);
      send_request(lltd_pkg::OP_ADD, 3'd5);
      send_request(lltd_pkg::OP_ADD, 3'd6);
      send_request(lltd_pkg::OP_REMOVE, 3'd5);
      send_request(lltd_pkg::OP_REMOVE, 3'd6);
      send_request(lltd_pkg::OP_DISPATCH, 3'd1);
      send_request(lltd_pkg::OP_BALANCE, 3'd4);
      wait_quiet(SETTLE);

      run_phase(18, 50, 3'd2, 310);
      run_phase(50, 18, 3'd5, 310);
      // full rate; the receiver holds long enough for the input to back up
      hold_wanted = 1'b1;
      run_phase(0, 0, 3'd7, 300);

      // a last mixed burst on whatever the counts have become
      send_request(lltd_pkg::OP_DISPATCH, 3'd0);
      send_request(lltd_pkg::OP_ADD, 3'd2);
      send_request(lltd_pkg::OP_BALANCE, 3'd0);
      send_request(lltd_pkg::OP_REMOVE, 3'd4);
      send_request(lltd_pkg::OP_DISPATCH, 3'd6);
      send_request(lltd_pkg::OP_BALANCE, 3'd1);
      wait_quiet(40);

      $display("covered %0d requests: directed corners, three idle mixes and a %0d-cycle",
               sent, HOLD_CYCLES);
      $display("response hold that backed the request queue up");
      if (failures == 0) begin
         $display("PASS least_loaded_task_dispatcher");
      end else begin
         $display("FAIL least_loaded_task_dispatcher");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d responses outstanding", pending);
      $display("FAIL least_loaded_task_dispatcher");
      $finish;
   end

endmodule
